[sv/wtsc_pkg.sv]
// ----------------------------------------------------------------------------
// wtsc_pkg: shared types and constants of the wave table sound channel
// Field widths, operation and register codes, beat structs, volume scaling.
// ----------------------------------------------------------------------------
package wtsc_pkg;

  localparam int OP_W     = 3;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 8;
  localparam int NIB_W    = 4;
  localparam int FREQ_W   = 11;
  localparam int PERIOD_W = 12;
  localparam int POS_W    = 5;
  localparam int LEN_W    = 8;
  localparam int VOL_W    = 3;
  localparam int RAM_ROWS = 32;
  localparam int ROW_W    = $clog2(RAM_ROWS);

  localparam logic [PERIOD_W-1:0] PERIOD_BASE = 12'd2048;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_LENGTH = 3'd1;
  localparam logic [OP_W-1:0] OP_REG_RD = 3'd2;
  localparam logic [OP_W-1:0] OP_REG_WR = 3'd3;
  localparam logic [OP_W-1:0] OP_RAM_RD = 3'd4;
  localparam logic [OP_W-1:0] OP_RAM_WR = 3'd5;

  // register indexes
  localparam logic [ADDR_W-1:0] REG_CTRL    = 4'd0;
  localparam logic [ADDR_W-1:0] REG_LENGTH  = 4'd1;
  localparam logic [ADDR_W-1:0] REG_VOLUME  = 4'd2;
  localparam logic [ADDR_W-1:0] REG_FREQ_LO = 4'd3;
  localparam logic [ADDR_W-1:0] REG_FREQ_HI = 4'd4;

  // volume codes
  localparam logic [VOL_W-1:0] VOL_MUTE    = 3'd0;
  localparam logic [VOL_W-1:0] VOL_FULL    = 3'd1;
  localparam logic [VOL_W-1:0] VOL_HALF    = 3'd2;
  localparam logic [VOL_W-1:0] VOL_QUARTER = 3'd3;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic              master_enable;
  } item_t;

  typedef struct packed {
    logic [NIB_W-1:0]  sample;
    logic [DATA_W-1:0] read_data;
    logic              channel_on;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [ROW_W-1:0]  row;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic [ROW_W-1:0] byte_row;
    logic [ROW_W-1:0] play_row;
  } ram_rd_addr_t;

  typedef struct packed {
    logic             bank_select;
    logic             play_bank;
    logic [POS_W-1:0] play_position;
  } play_ptr_t;

  // nibble scaled by 0, 1, 1/2, 1/4 or 3/4, rounded down
  function automatic logic [NIB_W-1:0] scale_level(input logic [NIB_W-1:0] nib,
                                                   input logic [VOL_W-1:0] vol);
    logic [NIB_W+1:0] triple;
    logic [NIB_W-1:0] lvl;
    triple = {1'b0, nib, 1'b0} + {2'b00, nib};
    case (vol)
      VOL_MUTE:    lvl = '0;
      VOL_FULL:    lvl = nib;
      VOL_HALF:    lvl = nib >> 1;
      VOL_QUARTER: lvl = nib >> 2;
      default:     lvl = triple[NIB_W+1:2];
    endcase
    return lvl;
  endfunction

endpackage

[sv/wtsc_ifs.sv]
// ----------------------------------------------------------------------------
// wtsc_ifs: beat channels of the wave table sound channel
// Command channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface wtsc_in_if;
  import wtsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;
  logic              master_enable;

  modport source (output valid, operation, address, write_data, master_enable,
                  input ready);
  modport sink (input valid, operation, address, write_data, master_enable,
                output ready);
endinterface

interface wtsc_out_if;
  import wtsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [NIB_W-1:0]  sample;
  logic [DATA_W-1:0] read_data;
  logic              channel_on;

  modport source (output valid, sample, read_data, channel_on, input ready);
  modport sink (input valid, sample, read_data, channel_on, output ready);
endinterface

[sv/wtsc_wave_ram.sv]
// ----------------------------------------------------------------------------
// wtsc_wave_ram: wave sample memory
// 32 bytes, one write port, two registered read ports, per-row valid bits
// so unwritten rows read as zero, and write-to-read bypass.
// ----------------------------------------------------------------------------
module wtsc_wave_ram (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wtsc_pkg::ram_wr_t     wr,
  input  logic                  rd_en,
  input  wtsc_pkg::ram_rd_addr_t rd_addr,
  output logic [wtsc_pkg::DATA_W-1:0] byte_data,
  output logic [wtsc_pkg::DATA_W-1:0] play_data
);
  import wtsc_pkg::*;

  logic [DATA_W-1:0]   mem [RAM_ROWS];
  logic [RAM_ROWS-1:0] valid_r;
  logic [DATA_W-1:0]   byte_q_r;
  logic [DATA_W-1:0]   play_q_r;
  logic [DATA_W-1:0]   wd_r;
  logic                byte_hit_r;
  logic                play_hit_r;
  logic                byte_vld_r;
  logic                play_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.row] <= wr.data;
    end
    if (rd_en) begin
      byte_q_r   <= mem[rd_addr.byte_row];
      play_q_r   <= mem[rd_addr.play_row];
      wd_r       <= wr.data;
      byte_hit_r <= wr.en && (wr.row == rd_addr.byte_row);
      play_hit_r <= wr.en && (wr.row == rd_addr.play_row);
      byte_vld_r <= valid_r[rd_addr.byte_row];
      play_vld_r <= valid_r[rd_addr.play_row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.row] <= 1'b1;
    end
  end

  assign byte_data = byte_hit_r ? wd_r : (byte_vld_r ? byte_q_r : '0);
  assign play_data = play_hit_r ? wd_r : (play_vld_r ? play_q_r : '0);

endmodule

[sv/wtsc_exec.sv]
// ----------------------------------------------------------------------------
// wtsc_exec: channel state and single-pass beat execution
// Holds the channel registers and computes the next state and result of
// the beat in the input register.
// ----------------------------------------------------------------------------
module wtsc_exec (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  wtsc_pkg::item_t             item,
  input  logic [wtsc_pkg::DATA_W-1:0] ram_byte,
  input  logic [wtsc_pkg::DATA_W-1:0] play_byte,
  output wtsc_pkg::result_t           result,
  output wtsc_pkg::ram_wr_t           ram_wr,
  output wtsc_pkg::play_ptr_t         ptr_nxt
);
  import wtsc_pkg::*;

  logic                two_bank_r,  two_bank_nxt;
  logic                bank_sel_r,  bank_sel_nxt;
  logic                dac_on_r,    dac_on_nxt;
  logic [LEN_W-1:0]    len_cnt_r,   len_cnt_nxt;
  logic [VOL_W-1:0]    vol_r,       vol_nxt;
  logic [FREQ_W-1:0]   freq_r,      freq_nxt;
  logic                len_en_r,    len_en_nxt;
  logic                chan_en_r,   chan_en_nxt;
  logic [NIB_W-1:0]    level_r,     level_nxt;
  logic [POS_W-1:0]    play_pos_r,  play_pos_nxt;
  logic                play_bank_r, play_bank_nxt;
  logic [NIB_W-1:0]    nibble_r,    nibble_nxt;
  logic [PERIOD_W-1:0] period_r,    period_nxt;

  logic [DATA_W-1:0]   rd_data;
  logic [FREQ_W-1:0]   freq_trig;
  logic [NIB_W-1:0]    fetched;
  logic [DATA_W-1:0]   d;

  assign d         = item.write_data;
  assign freq_trig = {d[2:0], freq_r[7:0]};
  assign fetched   = play_pos_r[0] ? play_byte[NIB_W-1:0] : play_byte[DATA_W-1:NIB_W];

  always_comb begin
    two_bank_nxt  = two_bank_r;
    bank_sel_nxt  = bank_sel_r;
    dac_on_nxt    = dac_on_r;
    len_cnt_nxt   = len_cnt_r;
    vol_nxt       = vol_r;
    freq_nxt      = freq_r;
    len_en_nxt    = len_en_r;
    chan_en_nxt   = chan_en_r;
    level_nxt     = level_r;
    play_pos_nxt  = play_pos_r;
    play_bank_nxt = play_bank_r;
    nibble_nxt    = nibble_r;
    period_nxt    = period_r;
    rd_data       = '0;
    ram_wr.en     = 1'b0;
    ram_wr.row    = {bank_sel_r & item.master_enable, item.address};
    ram_wr.data   = d;
    case (item.operation)
      OP_TICK: begin
        if (period_r != '0) begin
          period_nxt = period_r - 12'd1;
          if (period_r == 12'd1) begin
            period_nxt   = PERIOD_BASE - {1'b0, freq_r};
            nibble_nxt   = fetched;
            play_pos_nxt = play_pos_r + 5'd1;
            if (play_pos_r == '1) begin
              play_bank_nxt = play_bank_r ^ two_bank_r;
            end
          end
        end
        level_nxt = chan_en_r ? scale_level(nibble_nxt, vol_r) : '0;
      end
      OP_LENGTH: begin
        if (chan_en_r && len_en_r) begin
          len_cnt_nxt = len_cnt_r + 8'd1;
          if (len_cnt_r == '1) begin
            chan_en_nxt = 1'b0;
          end
        end
      end
      OP_REG_RD: begin
        unique case (item.address)
          REG_CTRL:    rd_data = {dac_on_r, bank_sel_r, two_bank_r, 5'b0};
          REG_VOLUME:  rd_data = {vol_r, 5'b0};
          REG_FREQ_HI: rd_data = {1'b0, len_en_r, 6'b0};
          default:     rd_data = '0;
        endcase
      end
      OP_REG_WR: begin
        unique case (item.address)
          REG_CTRL: begin
            two_bank_nxt = d[5];
            bank_sel_nxt = d[6];
            dac_on_nxt   = d[7];
            if (!d[7]) begin
              chan_en_nxt = 1'b0;
            end
          end
          REG_LENGTH: begin
            len_cnt_nxt = d;
          end
          REG_VOLUME: begin
            vol_nxt = d[7:5];
          end
          REG_FREQ_LO: begin
            freq_nxt = {freq_r[10:8], d};
          end
          REG_FREQ_HI: begin
            freq_nxt   = freq_trig;
            len_en_nxt = d[6];
            if (d[7]) begin
              chan_en_nxt   = dac_on_r;
              period_nxt    = PERIOD_BASE - {1'b0, freq_trig};
              play_pos_nxt  = '0;
              play_bank_nxt = two_bank_r ? 1'b0 : bank_sel_r;
            end
          end
          default: begin
          end
        endcase
      end
      OP_RAM_RD: begin
        rd_data = ram_byte;
      end
      OP_RAM_WR: begin
        ram_wr.en = fire;
      end
      default: begin
      end
    endcase
  end

  assign result.sample     = level_nxt;
  assign result.read_data  = rd_data;
  assign result.channel_on = chan_en_nxt;

  assign ptr_nxt.bank_select   = fire ? bank_sel_nxt  : bank_sel_r;
  assign ptr_nxt.play_bank     = fire ? play_bank_nxt : play_bank_r;
  assign ptr_nxt.play_position = fire ? play_pos_nxt  : play_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      two_bank_r  <= 1'b0;
      bank_sel_r  <= 1'b0;
      dac_on_r    <= 1'b0;
      len_cnt_r   <= '0;
      vol_r       <= '0;
      freq_r      <= '0;
      len_en_r    <= 1'b0;
      chan_en_r   <= 1'b0;
      level_r     <= '0;
      play_pos_r  <= '0;
      play_bank_r <= 1'b0;
      nibble_r    <= '0;
      period_r    <= '0;
    end else if (fire) begin
      two_bank_r  <= two_bank_nxt;
      bank_sel_r  <= bank_sel_nxt;
      dac_on_r    <= dac_on_nxt;
      len_cnt_r   <= len_cnt_nxt;
      vol_r       <= vol_nxt;
      freq_r      <= freq_nxt;
      len_en_r    <= len_en_nxt;
      chan_en_r   <= chan_en_nxt;
      level_r     <= level_nxt;
      play_pos_r  <= play_pos_nxt;
      play_bank_r <= play_bank_nxt;
      nibble_r    <= nibble_nxt;
      period_r    <= period_nxt;
    end
  end

`ifndef SYNTHESIS
  a_enable_needs_dac: assert property (@(posedge clk) disable iff (!rst_n)
    chan_en_r |-> dac_on_r)
    else $error("channel enabled with dac off");

  a_period_bound: assert property (@(posedge clk) disable iff (!rst_n)
    period_r <= PERIOD_BASE)
    else $error("period counter out of range");

  a_silent_when_off: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (item.operation == OP_TICK) && !chan_en_r) |=> (level_r == '0))
    else $error("disabled channel produced a nonzero level");
`endif

endmodule

[sv/wave_table_sound_channel_core.sv]
// path: an accepted command beat goes through the input register and the result register
// throughput: one beat per cycle while the result side does not stall, set by the execute stage
// between the input register and the result register
// reset: synchronous active-low rst_n clears all channel state and the
// wave memory valid bits, so the memory reads as zero until written
// ----------------------------------------------------------------------------
// wave_table_sound_channel_core: wave table sound channel top level
// Input register with memory read, single-pass execute, result register.
// ----------------------------------------------------------------------------
module wave_table_sound_channel_core (
  input  logic            clk,
  input  logic            rst_n,
  wtsc_in_if.sink         in_bus,
  wtsc_out_if.source      out_bus
);
  import wtsc_pkg::*;

  item_t        item_r;
  logic         item_v_r;
  result_t      res_r;
  logic         res_v_r;
  logic         exec_fire;
  logic         in_fire;
  result_t      exec_res;
  ram_wr_t      ram_wr;
  ram_rd_addr_t rd_addr;
  play_ptr_t    ptr_nxt;
  logic [DATA_W-1:0] ram_byte;
  logic [DATA_W-1:0] play_byte;

  assign exec_fire    = item_v_r && (!res_v_r || out_bus.ready);
  assign in_bus.ready = !item_v_r || exec_fire;
  assign in_fire      = in_bus.valid && in_bus.ready;

  // read addresses follow the state left by the beat executing now
  assign rd_addr.byte_row = {ptr_nxt.bank_select & in_bus.master_enable, in_bus.address};
  assign rd_addr.play_row = {ptr_nxt.play_bank, ptr_nxt.play_position[POS_W-1:1]};

  wtsc_wave_ram u_ram (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (ram_wr),
    .rd_en     (in_fire),
    .rd_addr   (rd_addr),
    .byte_data (ram_byte),
    .play_data (play_byte)
  );

  wtsc_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (exec_fire),
    .item      (item_r),
    .ram_byte  (ram_byte),
    .play_byte (play_byte),
    .result    (exec_res),
    .ram_wr    (ram_wr),
    .ptr_nxt   (ptr_nxt)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.operation     <= in_bus.operation;
      item_r.address       <= in_bus.address;
      item_r.write_data    <= in_bus.write_data;
      item_r.master_enable <= in_bus.master_enable;
    end
    if (exec_fire) begin
      res_r <= exec_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      res_v_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        item_v_r <= 1'b1;
      end else if (exec_fire) begin
        item_v_r <= 1'b0;
      end
      if (exec_fire) begin
        res_v_r <= 1'b1;
      end else if (out_bus.ready) begin
        res_v_r <= 1'b0;
      end
    end
  end

  assign out_bus.valid      = res_v_r;
  assign out_bus.sample     = res_r.sample;
  assign out_bus.read_data  = res_r.read_data;
  assign out_bus.channel_on = res_r.channel_on;

`ifndef SYNTHESIS
  a_stalled_beat_held: assert property (@(posedge clk) disable iff (!rst_n)
    (item_v_r && !exec_fire) |=> (item_v_r && $stable(item_r)))
    else $error("stalled beat lost from input register");

  a_exec_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> res_v_r)
    else $error("executed beat missing from result register");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !res_v_r |-> in_bus.ready)
    else $error("input stalled with empty result register");
`endif

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the wave table sound channel core
// Command beats come from a queue filled up front: a directed opening, then
// random scenes that load wave memory, program and trigger the channel and
// play it out with sample ticks, length clocks and reads. A beat-level model
// of the channel predicts every result beat, which is checked field by field
// in order. Both sides of the handshake stall at random.
// ----------------------------------------------------------------------------
module tb;
  import wtsc_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
  localparam int RANDOM_ITEMS   = 800;
  localparam int STALL_PCT      = 33;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wtsc_in_if  in_if ();
  wtsc_out_if out_if ();

  wave_table_sound_channel_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if)
  );

  always #1 clk = ~clk;

  // channel model state
  logic                two_bank  = 1'b0;
  logic                bank_sel  = 1'b0;
  logic                dac_en    = 1'b0;
  logic [LEN_W-1:0]    len_count = '0;
  logic [VOL_W-1:0]    vol_code  = '0;
  logic [FREQ_W-1:0]   freq      = '0;
  logic                len_en    = 1'b0;
  logic                chan_en   = 1'b0;
  logic [NIB_W-1:0]    level     = '0;
  logic [NIB_W-1:0]    wave_mem [2*RAM_ROWS];
  logic [POS_W-1:0]    pos       = '0;
  logic                play_bank = 1'b0;
  logic [NIB_W-1:0]    nibble    = '0;
  logic [PERIOD_W-1:0] period    = '0;

  int fetches, swaps, expiries, triggers;

  item_t   cmd_queue [$];
  result_t expected_results [$];
  item_t   drive_cmd;
  result_t seen, want;
  logic    in_fire = 1'b0;
  int      useful_items, items_sent, beats_checked, mismatches, idle_cycles, leftover;

  function automatic logic [NIB_W-1:0] volume_scaled(input logic [NIB_W-1:0] nib,
                                                     input logic [VOL_W-1:0] vol);
    logic [2:0]       quarters;
    logic [NIB_W+2:0] prod;
    case (vol)
      VOL_MUTE:    quarters = 3'd0;
      VOL_FULL:    quarters = 3'd4;
      VOL_HALF:    quarters = 3'd2;
      VOL_QUARTER: quarters = 3'd1;
      default:     quarters = 3'd3;
    endcase
    prod = {3'b000, nib} * {4'b0000, quarters};
    return prod[NIB_W+1:2];
  endfunction

  function automatic result_t channel_step(input item_t cmd);
    result_t    res;
    logic [5:0] ram_idx;
    res = '0;
    ram_idx = {bank_sel & cmd.master_enable, cmd.address, 1'b0};
    case (cmd.operation)
      OP_TICK: begin
        if (period != '0) begin
          period = period - 12'd1;
          if (period == '0) begin
            period = PERIOD_BASE - {1'b0, freq};
            nibble = wave_mem[{play_bank, pos}];
            pos = pos + 5'd1;
            fetches++;
            if (pos == '0 && two_bank) begin
              play_bank = ~play_bank;
              swaps++;
            end
          end
        end
        level = chan_en ? volume_scaled(nibble, vol_code) : '0;
      end
      OP_LENGTH: begin
        if (chan_en && len_en) begin
          len_count = len_count + 8'd1;
          if (len_count == '0) begin
            chan_en = 1'b0;
            expiries++;
          end
        end
      end
      OP_REG_RD: begin
        case (cmd.address)
          REG_CTRL:    res.read_data = {dac_en, bank_sel, two_bank, 5'b0};
          REG_VOLUME:  res.read_data = {vol_code, 5'b0};
          REG_FREQ_HI: res.read_data = {1'b0, len_en, 6'b0};
          default:     res.read_data = '0;
        endcase
      end
      OP_REG_WR: begin
        case (cmd.address)
          REG_CTRL: begin
            two_bank = cmd.write_data[5];
            bank_sel = cmd.write_data[6];
            dac_en   = cmd.write_data[7];
            if (!dac_en) chan_en = 1'b0;
          end
          REG_LENGTH:  len_count = cmd.write_data;
          REG_VOLUME:  vol_code = cmd.write_data[7:5];
          REG_FREQ_LO: freq[7:0] = cmd.write_data;
          REG_FREQ_HI: begin
            freq[FREQ_W-1:8] = cmd.write_data[2:0];
            len_en = cmd.write_data[6];
            if (cmd.write_data[7]) begin
              chan_en   = dac_en;
              period    = PERIOD_BASE - {1'b0, freq};
              pos       = '0;
              play_bank = two_bank ? 1'b0 : bank_sel;
              triggers++;
            end
          end
          default: ;
        endcase
      end
      OP_RAM_RD: res.read_data = {wave_mem[ram_idx], wave_mem[ram_idx | 6'd1]};
      OP_RAM_WR: begin
        wave_mem[ram_idx]         = cmd.write_data[7:4];
        wave_mem[ram_idx | 6'd1]  = cmd.write_data[3:0];
      end
      default: ;
    endcase
    res.sample     = level;
    res.channel_on = chan_en;
    return res;
  endfunction

  task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data, input logic men);
    item_t cmd;
    cmd.operation     = op;
    cmd.address       = addr;
    cmd.write_data    = data;
    cmd.master_enable = men;
    cmd_queue.push_back(cmd);
    if (op <= OP_RAM_WR && !(op == OP_REG_WR && addr > REG_FREQ_HI)) useful_items++;
  endtask

  // one random scene: mostly program, trigger and play; sometimes noise
  task automatic queue_scene();
    logic [DATA_W-1:0] d;
    int                pick;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(8, 1))
        queue_cmd(OP_W'($urandom_range(OP_UNUSED_HI)), ADDR_W'($urandom),
                  DATA_W'($urandom), 1'($urandom));
    end else begin
      repeat ($urandom_range(4))
        queue_cmd(OP_RAM_WR, ADDR_W'($urandom), DATA_W'($urandom), 1'($urandom));
      d = DATA_W'($urandom);
      if ($urandom_range(9) != 0) d[7] = 1'b1;
      queue_cmd(OP_REG_WR, REG_CTRL, d, 1'($urandom));
      queue_cmd(OP_REG_WR, REG_VOLUME, DATA_W'($urandom), 1'($urandom));
      d = DATA_W'($urandom);
      if ($urandom_range(1)) d[7:4] = 4'hf;
      queue_cmd(OP_REG_WR, REG_LENGTH, d, 1'($urandom));
      d = DATA_W'($urandom);
      if ($urandom_range(3) != 0) d[7:3] = 5'h1f;
      queue_cmd(OP_REG_WR, REG_FREQ_LO, d, 1'($urandom));
      d = DATA_W'($urandom);
      if ($urandom_range(3) != 0) d[2:0] = 3'h7;
      d[7] = ($urandom_range(4) != 0);
      queue_cmd(OP_REG_WR, REG_FREQ_HI, d, 1'($urandom));
      repeat ($urandom_range(60, 10)) begin
        pick = $urandom_range(99);
        if (pick < 60)
          queue_cmd(OP_TICK, ADDR_W'($urandom), DATA_W'($urandom), 1'($urandom));
        else if (pick < 72)
          queue_cmd(OP_LENGTH, ADDR_W'($urandom), DATA_W'($urandom), 1'($urandom));
        else if (pick < 80)
          queue_cmd(OP_REG_RD,
                    $urandom_range(1) ? ADDR_W'($urandom_range(REG_FREQ_HI))
                                      : ADDR_W'($urandom),
                    DATA_W'($urandom), 1'($urandom));
        else if (pick < 88)
          queue_cmd(OP_RAM_RD, ADDR_W'($urandom), DATA_W'($urandom), 1'($urandom));
        else if (pick < 94)
          queue_cmd(OP_RAM_WR, ADDR_W'($urandom), DATA_W'($urandom), 1'($urandom));
        else
          queue_cmd(OP_REG_WR, ADDR_W'($urandom_range(REG_FREQ_HI)), DATA_W'($urandom),
                    1'($urandom));
      end
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // no stalls on either side through a middle stretch of the run
  function automatic logic stall_now();
    return !(items_sent >= 300 && items_sent < 500) && ($urandom_range(99) < STALL_PCT);
  endfunction

  // command driver
  always @(negedge clk) begin
    if (rst_n && (!in_if.valid || in_fire)) begin
      if (cmd_queue.size() > 0 && !stall_now()) begin
        drive_cmd = cmd_queue.pop_front();
        in_if.valid         <= 1'b1;
        in_if.operation     <= drive_cmd.operation;
        in_if.address       <= drive_cmd.address;
        in_if.write_data    <= drive_cmd.write_data;
        in_if.master_enable <= drive_cmd.master_enable;
        items_sent++;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk) begin
    out_if.ready <= rst_n && !stall_now();
  end

  // monitor and checker
  always @(posedge clk) begin
    in_fire <= in_if.valid && in_if.ready;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        seen.sample     = out_if.sample;
        seen.read_data  = out_if.read_data;
        seen.channel_on = out_if.channel_on;
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("result beat with nothing pending: %p", seen));
        end else begin
          want = expected_results.pop_front();
          if (seen.sample !== want.sample)
            note_mismatch($sformatf("beat %0d sample: expected %0h, got %0h",
                                    beats_checked, want.sample, seen.sample));
          if (seen.read_data !== want.read_data)
            note_mismatch($sformatf("beat %0d read_data: expected %02h, got %02h",
                                    beats_checked, want.read_data, seen.read_data));
          if (seen.channel_on !== want.channel_on)
            note_mismatch($sformatf("beat %0d channel_on: expected %0b, got %0b",
                                    beats_checked, want.channel_on, seen.channel_on));
        end
        beats_checked++;
      end
      if (in_if.valid && in_if.ready)
        expected_results.push_back(channel_step({in_if.operation, in_if.address,
                                                 in_if.write_data, in_if.master_enable}));
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results pending",
               idle_cycles, expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_if.valid         = 1'b0;
    in_if.operation     = OP_TICK;
    in_if.address       = '0;
    in_if.write_data    = '0;
    in_if.master_enable = 1'b0;
    out_if.ready        = 1'b0;
    for (int i = 0; i < 2*RAM_ROWS; i++) wave_mem[i] = '0;

    // directed opening
    queue_cmd(OP_REG_RD, REG_CTRL, 8'h00, 1'b0);
    queue_cmd(OP_RAM_RD, 4'hf, 8'h00, 1'b1);
    queue_cmd(OP_TICK, 4'h0, 8'h00, 1'b0);
    queue_cmd(OP_RAM_WR, 4'h0, 8'hf0, 1'b0);
    queue_cmd(OP_RAM_WR, 4'hf, 8'h5a, 1'b1);
    queue_cmd(OP_REG_WR, REG_CTRL, 8'he0, 1'b0);
    queue_cmd(OP_RAM_WR, 4'h0, 8'hff, 1'b1);
    queue_cmd(OP_RAM_RD, 4'h0, 8'h00, 1'b1);
    queue_cmd(OP_RAM_RD, 4'h0, 8'h00, 1'b0);
    queue_cmd(OP_REG_RD, REG_CTRL, 8'h00, 1'b0);
    queue_cmd(OP_REG_WR, REG_VOLUME, 8'h20, 1'b0);
    queue_cmd(OP_REG_WR, REG_FREQ_LO, 8'hff, 1'b0);
    queue_cmd(OP_REG_WR, REG_FREQ_HI, 8'hc7, 1'b0);
    queue_cmd(OP_REG_RD, REG_FREQ_HI, 8'h00, 1'b0);
    queue_cmd(OP_REG_RD, REG_FREQ_LO, 8'h00, 1'b0);
    repeat (3) queue_cmd(OP_TICK, 4'h0, 8'h00, 1'b0);
    queue_cmd(OP_REG_WR, REG_VOLUME, 8'he0, 1'b0);
    queue_cmd(OP_REG_RD, REG_VOLUME, 8'h00, 1'b0);
    queue_cmd(OP_TICK, 4'h0, 8'h00, 1'b0);
    queue_cmd(OP_REG_WR, REG_LENGTH, 8'hfe, 1'b0);
    repeat (2) queue_cmd(OP_LENGTH, 4'h0, 8'h00, 1'b0);
    queue_cmd(OP_TICK, 4'h0, 8'h00, 1'b0);
    queue_cmd(OP_REG_WR, 4'h9, 8'hff, 1'b0);
    queue_cmd(OP_REG_RD, 4'hf, 8'h00, 1'b0);
    queue_cmd(OP_UNUSED_LO, 4'hf, 8'hff, 1'b1);
    queue_cmd(OP_UNUSED_HI, 4'h0, 8'h00, 1'b0);
    queue_cmd(OP_REG_WR, REG_CTRL, 8'h00, 1'b0);
    queue_cmd(OP_REG_WR, REG_FREQ_HI, 8'h80, 1'b0);

    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) queue_scene();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (cmd_queue.size() != 0 || in_if.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    leftover = expected_results.size();
    mismatches += leftover;

    $display("covered %0d command beats and %0d result beats checked",
             items_sent, beats_checked);
    $display("with %0d sample fetches, %0d bank swaps, %0d triggers, %0d length expiries",
             fetches, swaps, triggers, expiries);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
